### hw/rtl/priority_schedule_wait_times_unit_macros.svh
// assertion macros for the priority schedule wait times unit
// used by the checker module, no other dependencies
`ifndef PRIORITY_SCHEDULE_WAIT_TIMES_UNIT_MACROS_SVH
`define PRIORITY_SCHEDULE_WAIT_TIMES_UNIT_MACROS_SVH

// implication checked at every rising clock edge outside reset
`define PRSW_ASSERT(label, clk, rst_n, prop) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (prop)) \
        else $error("prsw assertion failed");

// a condition that holds on every cycle outside reset
`define PRSW_ALWAYS(label, clk, rst_n, expr) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (expr)) \
        else $error("prsw invariant failed");

`endif

### hw/rtl/prsw_pkg.sv
// shared types and constants of the priority schedule wait times unit
// no dependencies, used by every rtl module of the block
package prsw_pkg;

    localparam int MAX_PROCS = 16;
    localparam int ID_W      = 8;
    localparam int BURST_W   = 16;
    localparam int PRIO_W    = 8;
    localparam int TIME_W    = 20;
    localparam logic [TIME_W-1:0] TIME_MAX = {TIME_W{1'b1}};

    localparam int CNT_W  = $clog2(MAX_PROCS + 1);
    localparam int SUM_W  = TIME_W + $clog2(MAX_PROCS);
    localparam int DCNT_W = $clog2(SUM_W + 1);

    localparam int IN_TDATA_W  = ((ID_W + BURST_W + PRIO_W + 7) / 8) * 8;
    localparam int OUT_FIELD_W = ID_W + PRIO_W + BURST_W + 3 * TIME_W;
    localparam int OUT_TDATA_W = ((OUT_FIELD_W + 7) / 8) * 8;

    typedef struct packed {
        logic [PRIO_W-1:0]  prio;
        logic [BURST_W-1:0] burst;
        logic [ID_W-1:0]    id;
    } t_entry;

    typedef struct packed {
        logic ins;  // insert the new word at its sorted place
        logic pop;  // shift the whole chain one place toward the head
    } t_cell_ctl;

endpackage

### hw/rtl/priority_schedule_wait_times_unit.sv
// load: one word per cycle into a sorted chain of cells, ready only while loading
// after the word with tlast: one result per stored process, one per cycle when the
// output is not stalled; the final result, which also carries the average wait,
// follows the last pop once the bit-serial divider has finished
// synchronous active-low reset empties the chain and returns to loading
module priority_schedule_wait_times_unit (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              i_s_axis_tvalid,
    output logic                              o_s_axis_tready,
    // process_id, burst_time, priority_req
    input  logic [prsw_pkg::IN_TDATA_W-1:0]   i_s_axis_tdata,
    input  logic                              i_s_axis_tlast,
    output logic                              o_m_axis_tvalid,
    input  logic                              i_m_axis_tready,
    // out_process_id, out_priority, out_burst_time, waiting_time,
    // turnaround_time, average_wait, zero fill
    output logic [prsw_pkg::OUT_TDATA_W-1:0]  o_m_axis_tdata,
    // overflow
    output logic                              o_m_axis_tuser,
    output logic                              o_m_axis_tlast
);

    typedef enum logic [3:0] {
        S_LOAD = 4'b0001,
        S_EMIT = 4'b0010,
        S_DIV  = 4'b0100,
        S_DONE = 4'b1000
    } t_state;

    localparam int N = prsw_pkg::MAX_PROCS;

    t_state                        r_state;
    logic [prsw_pkg::CNT_W-1:0]    r_count;
    logic [prsw_pkg::CNT_W-1:0]    r_nprocs;
    logic                          r_dropped;
    logic [prsw_pkg::TIME_W-1:0]   r_elapsed;
    logic [prsw_pkg::SUM_W-1:0]    r_sum;
    logic                          r_out_valid;
    logic                          r_out_final;

    logic [prsw_pkg::ID_W-1:0]     r_out_id;
    logic [prsw_pkg::PRIO_W-1:0]   r_out_prio;
    logic [prsw_pkg::BURST_W-1:0]  r_out_burst;
    logic [prsw_pkg::TIME_W-1:0]   r_out_wait;
    logic [prsw_pkg::TIME_W-1:0]   r_out_tat;
    logic [prsw_pkg::TIME_W-1:0]   r_out_avg;
    logic                          r_out_ovf;

    prsw_pkg::t_entry              new_entry;
    prsw_pkg::t_cell_ctl           cell_ctl;
    prsw_pkg::t_entry              cell_entry [N];
    logic                          cell_valid [N];
    logic                          cell_take  [N];

    logic                          in_acc;
    logic                          full;
    logic                          pop;
    logic                          last_pop;
    logic [prsw_pkg::TIME_W:0]     tat_raw;
    logic [prsw_pkg::TIME_W-1:0]   n_elapsed;
    logic [prsw_pkg::SUM_W-1:0]    n_sum;
    logic                          div_done;
    logic [prsw_pkg::SUM_W-1:0]    div_quo;

    assign new_entry.id    = i_s_axis_tdata[prsw_pkg::ID_W-1:0];
    assign new_entry.burst = i_s_axis_tdata[prsw_pkg::ID_W +: prsw_pkg::BURST_W];
    assign new_entry.prio  =
        i_s_axis_tdata[prsw_pkg::ID_W + prsw_pkg::BURST_W +: prsw_pkg::PRIO_W];

    assign o_s_axis_tready = (r_state == S_LOAD);
    assign in_acc          = i_s_axis_tvalid && o_s_axis_tready;
    assign full            = (r_count == prsw_pkg::CNT_W'(N));
    assign pop             = (r_state == S_EMIT) && (!r_out_valid || i_m_axis_tready);
    assign last_pop        = pop && (r_count == prsw_pkg::CNT_W'(1));

    assign cell_ctl.ins = in_acc && !full;
    assign cell_ctl.pop = pop;

    // head of the chain is the next process in service order
    always_comb begin
        tat_raw = {1'b0, r_elapsed} + (prsw_pkg::TIME_W + 1)'(cell_entry[0].burst);
        if (tat_raw[prsw_pkg::TIME_W]) begin
            n_elapsed = prsw_pkg::TIME_MAX;
        end else begin
            n_elapsed = tat_raw[prsw_pkg::TIME_W-1:0];
        end
        n_sum = r_sum + prsw_pkg::SUM_W'(r_elapsed);
    end

    for (genvar k = 0; k < N; k++) begin : g_cell
        prsw_pkg::t_entry prev_entry;
        prsw_pkg::t_entry next_entry;
        logic             prev_valid;
        logic             prev_take;
        logic             next_valid;

        if (k == 0) begin : g_head
            assign prev_entry = '0;
            assign prev_valid = 1'b0;
            assign prev_take  = 1'b0;
        end else begin : g_body
            assign prev_entry = cell_entry[k-1];
            assign prev_valid = cell_valid[k-1];
            assign prev_take  = cell_take[k-1];
        end

        if (k == N - 1) begin : g_tail
            assign next_entry = '0;
            assign next_valid = 1'b0;
        end else begin : g_link
            assign next_entry = cell_entry[k+1];
            assign next_valid = cell_valid[k+1];
        end

        prsw_cell u_cell (
            .i_clk        (i_clk),
            .i_rst_n      (i_rst_n),
            .i_ctl        (cell_ctl),
            .i_new_entry  (new_entry),
            .i_prev_entry (prev_entry),
            .i_prev_valid (prev_valid),
            .i_prev_take  (prev_take),
            .i_next_entry (next_entry),
            .i_next_valid (next_valid),
            .o_entry      (cell_entry[k]),
            .o_valid      (cell_valid[k]),
            .o_take       (cell_take[k])
        );
    end

    prsw_div u_div (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (last_pop),
        .i_dividend (n_sum),
        .i_divisor  (r_nprocs),
        .o_done     (div_done),
        .o_quotient (div_quo)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_LOAD;
            r_count     <= '0;
            r_nprocs    <= '0;
            r_dropped   <= 1'b0;
            r_elapsed   <= '0;
            r_sum       <= '0;
            r_out_valid <= 1'b0;
            r_out_final <= 1'b0;
        end else begin
            unique case (r_state)
                S_LOAD: begin
                    if (in_acc) begin
                        if (full) begin
                            r_dropped <= 1'b1;
                        end else begin
                            r_count <= r_count + 1'b1;
                        end
                        if (i_s_axis_tlast) begin
                            r_nprocs  <= full ? r_count : r_count + 1'b1;
                            r_elapsed <= '0;
                            r_sum     <= '0;
                            r_state   <= S_EMIT;
                        end
                    end
                end
                S_EMIT: begin
                    if (pop) begin
                        r_count     <= r_count - 1'b1;
                        r_elapsed   <= n_elapsed;
                        r_sum       <= n_sum;
                        r_out_final <= 1'b0;
                        // the last word waits for the average
                        r_out_valid <= !last_pop;
                        if (last_pop) begin
                            r_state <= S_DIV;
                        end
                    end
                end
                S_DIV: begin
                    if (div_done) begin
                        r_out_valid <= 1'b1;
                        r_out_final <= 1'b1;
                        r_state     <= S_DONE;
                    end
                end
                S_DONE: begin
                    if (r_out_valid && i_m_axis_tready) begin
                        r_out_valid <= 1'b0;
                        r_dropped   <= 1'b0;
                        r_state     <= S_LOAD;
                    end
                end
                default: begin
                    r_state <= S_LOAD;
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (pop) begin
            r_out_id    <= cell_entry[0].id;
            r_out_prio  <= cell_entry[0].prio;
            r_out_burst <= cell_entry[0].burst;
            r_out_wait  <= r_elapsed;
            r_out_tat   <= n_elapsed;
            r_out_avg   <= '0;
            r_out_ovf   <= r_dropped;
        end else if ((r_state == S_DIV) && div_done) begin
            r_out_avg <= div_quo[prsw_pkg::TIME_W-1:0];
        end
    end

    assign o_m_axis_tvalid = r_out_valid;
    assign o_m_axis_tlast  = r_out_final;
    assign o_m_axis_tuser  = r_out_ovf;
    assign o_m_axis_tdata  = {
        {(prsw_pkg::OUT_TDATA_W - prsw_pkg::OUT_FIELD_W){1'b0}},
        r_out_avg, r_out_tat, r_out_wait, r_out_burst, r_out_prio, r_out_id
    };

endmodule

### hw/rtl/prsw_cell.sv
// one cell of the sorted insertion chain of the schedule unit
// depends on prsw_pkg for the entry type and control struct
module prsw_cell (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  prsw_pkg::t_cell_ctl  i_ctl,
    input  prsw_pkg::t_entry     i_new_entry,
    input  prsw_pkg::t_entry     i_prev_entry,
    input  logic                 i_prev_valid,
    input  logic                 i_prev_take,
    input  prsw_pkg::t_entry     i_next_entry,
    input  logic                 i_next_valid,
    output prsw_pkg::t_entry     o_entry,
    output logic                 o_valid,
    output logic                 o_take
);

    prsw_pkg::t_entry r_entry;
    logic             r_valid;

    // strict compare keeps equal priorities in load order
    assign o_take  = !r_valid || (r_entry.prio > i_new_entry.prio);
    assign o_entry = r_entry;
    assign o_valid = r_valid;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (i_ctl.pop) begin
            r_valid <= i_next_valid;
        end else if (i_ctl.ins) begin
            if (i_prev_take) begin
                r_valid <= i_prev_valid;
            end else if (o_take) begin
                r_valid <= 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_ctl.pop) begin
            r_entry <= i_next_entry;
        end else if (i_ctl.ins) begin
            if (i_prev_take) begin
                r_entry <= i_prev_entry;
            end else if (o_take) begin
                r_entry <= i_new_entry;
            end
        end
    end

endmodule

### hw/rtl/prsw_div.sv
// restoring divider, one quotient bit per cycle, for the average wait
// depends on prsw_pkg for the sum and count widths
module prsw_div (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_start,
    input  logic [prsw_pkg::SUM_W-1:0]  i_dividend,
    input  logic [prsw_pkg::CNT_W-1:0]  i_divisor,
    output logic                        o_done,
    output logic [prsw_pkg::SUM_W-1:0]  o_quotient
);

    logic                         r_busy;
    logic                         r_done;
    logic [prsw_pkg::DCNT_W-1:0]  r_cnt;
    logic [prsw_pkg::CNT_W-1:0]   r_rem;
    logic [prsw_pkg::CNT_W-1:0]   r_dsr;
    logic [prsw_pkg::SUM_W-1:0]   r_quo;
    logic [prsw_pkg::CNT_W:0]     trial;
    logic                         q_bit;
    logic [prsw_pkg::CNT_W-1:0]   n_rem;

    always_comb begin
        trial = {r_rem, r_quo[prsw_pkg::SUM_W-1]};
        q_bit = (trial >= {1'b0, r_dsr});
        if (q_bit) begin
            n_rem = prsw_pkg::CNT_W'(trial - {1'b0, r_dsr});
        end else begin
            n_rem = trial[prsw_pkg::CNT_W-1:0];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
                r_cnt  <= prsw_pkg::DCNT_W'(prsw_pkg::SUM_W);
            end else if (r_busy) begin
                r_cnt <= r_cnt - 1'b1;
                if (r_cnt == prsw_pkg::DCNT_W'(1)) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_rem <= '0;
            r_dsr <= i_divisor;
            r_quo <= i_dividend;
        end else if (r_busy) begin
            r_rem <= n_rem;
            r_quo <= {r_quo[prsw_pkg::SUM_W-2:0], q_bit};
        end
    end

    assign o_done     = r_done;
    assign o_quotient = r_quo;

endmodule

### hw/rtl/prsw_checker.sv
// port-level checks of the priority schedule wait times unit, bound to the top level
// depends on prsw_pkg and the macro header
`include "priority_schedule_wait_times_unit_macros.svh"

module prsw_checker (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              i_s_axis_tvalid,
    input  logic                              o_s_axis_tready,
    input  logic                              i_s_axis_tlast,
    input  logic                              o_m_axis_tvalid,
    input  logic                              i_m_axis_tready,
    input  logic [prsw_pkg::OUT_TDATA_W-1:0]  o_m_axis_tdata,
    input  logic                              o_m_axis_tuser,
    input  logic                              o_m_axis_tlast
);

    localparam int WAIT_LO = prsw_pkg::ID_W + prsw_pkg::PRIO_W + prsw_pkg::BURST_W;
    localparam int TAT_LO  = WAIT_LO + prsw_pkg::TIME_W;

    logic                             in_last_acc;
    logic                             out_acc;
    logic                             out_last_acc;
    logic                             out_stall;
    logic [prsw_pkg::OUT_TDATA_W+1:0] out_word;
    logic [prsw_pkg::TIME_W-1:0]      out_wait;
    logic [prsw_pkg::TIME_W-1:0]      out_tat;

    assign in_last_acc  = i_s_axis_tvalid && o_s_axis_tready && i_s_axis_tlast;
    assign out_acc      = o_m_axis_tvalid && i_m_axis_tready;
    assign out_last_acc = out_acc && o_m_axis_tlast;
    assign out_stall    = o_m_axis_tvalid && !i_m_axis_tready;
    assign out_word     = {o_m_axis_tuser, o_m_axis_tlast, o_m_axis_tdata};
    assign out_wait     = o_m_axis_tdata[WAIT_LO +: prsw_pkg::TIME_W];
    assign out_tat      = o_m_axis_tdata[TAT_LO +: prsw_pkg::TIME_W];

    // a stalled result word holds
    `PRSW_ASSERT(a_out_hold, i_clk, i_rst_n, out_stall |=> o_m_axis_tvalid && $stable(out_word))

    // loading and emitting never overlap
    `PRSW_ALWAYS(a_no_overlap, i_clk, i_rst_n, !(o_m_axis_tvalid && o_s_axis_tready))

    // a closing input word stops loading
    `PRSW_ASSERT(a_stop_load, i_clk, i_rst_n, in_last_acc |=> !o_s_axis_tready)

    // the final result reopens loading
    `PRSW_ASSERT(a_reopen, i_clk, i_rst_n, out_last_acc |=> o_s_axis_tready)

    // turnaround never below waiting time
    `PRSW_ALWAYS(a_tat_ge_wait, i_clk, i_rst_n, !o_m_axis_tvalid || (out_tat >= out_wait))

endmodule

bind priority_schedule_wait_times_unit prsw_checker u_prsw_checker (
    .i_clk           (i_clk),
    .i_rst_n         (i_rst_n),
    .i_s_axis_tvalid (i_s_axis_tvalid),
    .o_s_axis_tready (o_s_axis_tready),
    .i_s_axis_tlast  (i_s_axis_tlast),
    .o_m_axis_tvalid (o_m_axis_tvalid),
    .i_m_axis_tready (i_m_axis_tready),
    .o_m_axis_tdata  (o_m_axis_tdata),
    .o_m_axis_tuser  (o_m_axis_tuser),
    .o_m_axis_tlast  (o_m_axis_tlast)
);

### tb/sv/priority_schedule_wait_times_unit_test.sv
// self-checking testbench for the priority schedule wait times unit
// depends on prsw_pkg and priority_schedule_wait_times_unit, nothing else
module priority_schedule_wait_times_unit_test;
    timeunit 1ns;
    timeprecision 1ps;

    import prsw_pkg::*;

    typedef struct {
        t_entry ent;
        logic   last;
    } proc_word_t;

    typedef struct {
        logic [ID_W-1:0]    id;
        logic [PRIO_W-1:0]  prio;
        logic [BURST_W-1:0] burst;
        logic [TIME_W-1:0]  wait_t;
        logic [TIME_W-1:0]  tat;
        logic [TIME_W-1:0]  avg;
        logic               fin;
        logic               ovf;
    } sched_result_t;

    logic                   i_clk;
    logic                   i_rst_n;
    logic                   i_s_axis_tvalid;
    logic                   o_s_axis_tready;
    logic [IN_TDATA_W-1:0]  i_s_axis_tdata;   // process_id, burst_time, priority_req
    logic                   i_s_axis_tlast;
    logic                   o_m_axis_tvalid;
    logic                   i_m_axis_tready;
    // out_process_id, out_priority, out_burst_time, waiting_time,
    // turnaround_time, average_wait, zero fill
    logic [OUT_TDATA_W-1:0] o_m_axis_tdata;
    logic                   o_m_axis_tuser;   // overflow
    logic                   o_m_axis_tlast;   // final_result

    priority_schedule_wait_times_unit u_dut (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_s_axis_tvalid (i_s_axis_tvalid),
        .o_s_axis_tready (o_s_axis_tready),
        .i_s_axis_tdata  (i_s_axis_tdata),
        .i_s_axis_tlast  (i_s_axis_tlast),
        .o_m_axis_tvalid (o_m_axis_tvalid),
        .i_m_axis_tready (i_m_axis_tready),
        .o_m_axis_tdata  (o_m_axis_tdata),
        .o_m_axis_tuser  (o_m_axis_tuser),
        .o_m_axis_tlast  (o_m_axis_tlast)
    );

    proc_word_t    proc_words[$];
    sched_result_t sched_expected[$];
    t_entry        loaded_set[$];
    bit            set_dropped = 1'b0;
    int            error_count = 0;
    int            word_count  = 0;
    int            in_gap;
    int            out_stall;
    bit            steady;

    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    function automatic int gap_len();
        int r;
        r = $urandom_range(99);
        if (steady || r < 55) return 0;
        if (r < 92) return $urandom_range(3, 1);
        return $urandom_range(30, 8);
    endfunction

    // stores one word, on tlast orders the set by priority (stable) and predicts the schedule
    function automatic void load_process(t_entry e, logic last);
        t_entry        tbl[MAX_PROCS];
        t_entry        key;
        sched_result_t r;
        int            n;
        int            j;
        int            elapsed;
        int            tat;
        longint        wait_sum;

        if (loaded_set.size() < MAX_PROCS) loaded_set.push_back(e);
        else set_dropped = 1'b1;
        if (!last) return;

        n = loaded_set.size();
        for (int i = 0; i < n; i++) tbl[i] = loaded_set[i];
        for (int i = 1; i < n; i++) begin
            key = tbl[i];
            j = i;
            while (j > 0 && tbl[j-1].prio > key.prio) begin
                tbl[j] = tbl[j-1];
                j--;
            end
            tbl[j] = key;
        end

        elapsed  = 0;
        wait_sum = 0;
        for (int k = 0; k < n; k++) begin
            tat = elapsed + int'(tbl[k].burst);
            if (tat > int'(TIME_MAX)) tat = int'(TIME_MAX);
            r.id     = tbl[k].id;
            r.prio   = tbl[k].prio;
            r.burst  = tbl[k].burst;
            r.wait_t = TIME_W'(elapsed);
            r.tat    = TIME_W'(tat);
            r.fin    = (k == n - 1);
            r.avg    = '0;
            r.ovf    = set_dropped;
            wait_sum += longint'(elapsed);
            if (r.fin) r.avg = TIME_W'(wait_sum / n);
            sched_expected.push_back(r);
            elapsed = tat;
        end
        loaded_set.delete();
        set_dropped = 1'b0;
    endfunction

    // input side: one word from the queue at a time, random gaps between words
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            i_s_axis_tvalid <= 1'b0;
            i_s_axis_tdata  <= '0;
            i_s_axis_tlast  <= 1'b0;
            in_gap          <= 0;
        end else begin
            if (i_s_axis_tvalid && o_s_axis_tready) begin
                load_process(t_entry'(i_s_axis_tdata[ID_W+BURST_W+PRIO_W-1:0]), i_s_axis_tlast);
            end
            if (!i_s_axis_tvalid || o_s_axis_tready) begin
                if (in_gap > 0) begin
                    in_gap          <= in_gap - 1;
                    i_s_axis_tvalid <= 1'b0;
                end else if (proc_words.size() > 0) begin
                    i_s_axis_tdata  <= IN_TDATA_W'(proc_words[0].ent);
                    i_s_axis_tlast  <= proc_words[0].last;
                    i_s_axis_tvalid <= 1'b1;
                    void'(proc_words.pop_front());
                    in_gap          <= gap_len();
                end else begin
                    i_s_axis_tvalid <= 1'b0;
                end
            end
        end
    end

    // output side: compare each word with the oldest expected result
    always @(posedge i_clk) begin
        sched_result_t e;
        if (!i_rst_n) begin
            i_m_axis_tready <= 1'b0;
            out_stall       <= 0;
            steady          <= 1'b0;
        end else begin
            if ($urandom_range(299) == 0) steady <= !steady;
            if (o_m_axis_tvalid && i_m_axis_tready) begin
                if (sched_expected.size() == 0) begin
                    $error("result word with no expected result");
                    error_count++;
                end else begin
                    e = sched_expected.pop_front();
                    // tdata: id [7:0], prio [15:8], burst [31:16], wait [51:32],
                    // turnaround [71:52], average [91:72]
                    if (o_m_axis_tdata[7:0] !== e.id) begin
                        $error("out_process_id expected %0d got %0d", e.id, o_m_axis_tdata[7:0]);
                        error_count++;
                    end
                    if (o_m_axis_tdata[15:8] !== e.prio) begin
                        $error("out_priority expected %0d got %0d", e.prio, o_m_axis_tdata[15:8]);
                        error_count++;
                    end
                    if (o_m_axis_tdata[31:16] !== e.burst) begin
                        $error("out_burst_time expected %0d got %0d", e.burst,
                               o_m_axis_tdata[31:16]);
                        error_count++;
                    end
                    if (o_m_axis_tdata[51:32] !== e.wait_t) begin
                        $error("waiting_time expected %0d got %0d", e.wait_t,
                               o_m_axis_tdata[51:32]);
                        error_count++;
                    end
                    if (o_m_axis_tdata[71:52] !== e.tat) begin
                        $error("turnaround_time expected %0d got %0d", e.tat,
                               o_m_axis_tdata[71:52]);
                        error_count++;
                    end
                    if (o_m_axis_tdata[91:72] !== e.avg) begin
                        $error("average_wait expected %0d got %0d", e.avg, o_m_axis_tdata[91:72]);
                        error_count++;
                    end
                    if (o_m_axis_tlast !== e.fin) begin
                        $error("final_result expected %0d got %0d", e.fin, o_m_axis_tlast);
                        error_count++;
                    end
                    if (o_m_axis_tuser !== e.ovf) begin
                        $error("overflow expected %0d got %0d", e.ovf, o_m_axis_tuser);
                        error_count++;
                    end
                end
            end
            if (out_stall > 0) begin
                out_stall       <= out_stall - 1;
                i_m_axis_tready <= 1'b0;
            end else if (!steady && $urandom_range(99) < 20) begin
                out_stall       <= gap_len();
                i_m_axis_tready <= 1'b0;
            end else begin
                i_m_axis_tready <= 1'b1;
            end
        end
    end

    function automatic void add_word(int id, int burst, int prio, bit last);
        proc_word_t w;
        w.ent.id    = ID_W'(id);
        w.ent.burst = BURST_W'(burst);
        w.ent.prio  = PRIO_W'(prio);
        w.last      = last;
        proc_words.push_back(w);
        word_count++;
    endfunction

    // a random set of n processes, the last one flagged
    function automatic void add_random_set(int n);
        int prio_mode;
        int burst_mode;
        int prio;
        int burst;
        prio_mode  = $urandom_range(3);
        burst_mode = $urandom_range(3);
        for (int i = 0; i < n; i++) begin
            case (prio_mode)
                0: prio = $urandom_range(3);                    // many ties
                1: prio = $urandom_range(1) ? 255 : 0;
                default: prio = $urandom_range(255);
            endcase
            case (burst_mode)
                0: burst = $urandom_range(15);
                1: burst = $urandom_range(65535, 60000);        // large sums
                default: burst = $urandom_range(65535);
            endcase
            add_word($urandom_range(255), burst, prio, i == n - 1);
        end
    endfunction

    initial begin
        int r;
        i_rst_n = 1'b0;

        // single process sets at both extremes
        add_word(0, 0, 0, 1'b1);
        add_word(255, 65535, 255, 1'b1);
        // ties in input order, priorities given out of sorted order
        add_word(10, 5, 7, 1'b0);
        add_word(11, 3, 2, 1'b0);
        add_word(12, 9, 7, 1'b0);
        add_word(13, 1, 2, 1'b1);
        // table full: two words dropped, tlast on a dropped word, maximum sums
        for (int i = 0; i < MAX_PROCS + 2; i++)
            add_word(i, 65535, (MAX_PROCS + 2 - i) % 4, i == MAX_PROCS + 1);

        while (word_count < 520) begin
            r = $urandom_range(99);
            if (r < 10) add_random_set($urandom_range(MAX_PROCS + 4, MAX_PROCS + 1));
            else if (r < 25) add_random_set(MAX_PROCS);
            else add_random_set($urandom_range(MAX_PROCS, 1));
        end

        repeat (7) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // sampled away from the active edge so the clocked blocks have settled
        while (proc_words.size() > 0 || i_s_axis_tvalid || sched_expected.size() > 0)
            @(negedge i_clk);
        // room for a stray word
        repeat (100) @(posedge i_clk);

        if (error_count == 0) begin
            $display("simulation ok");
        end else begin
            $display("simulation failed");
        end
        $finish;
    end

    initial begin
        #5ms;
        $display("simulation failed");
        $finish;
    end

endmodule
